FILE: sv/tbns_pkg.sv
// ----------------------------------------------------------------------------
// tbns_pkg
// Shared types and constants for the token bus node statistics monitor.
// ----------------------------------------------------------------------------
package tbns_pkg;

  localparam int NUM_NODES_DEF  = 256;
  localparam int STAT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  // Request codes
  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Frame type codes
  localparam logic [7:0] KIND_TOKEN      = 8'd0;
  localparam logic [7:0] KIND_POLL       = 8'd1;
  localparam logic [7:0] KIND_POLL_REPLY = 8'd2;
  localparam logic [7:0] KIND_DER        = 8'd5;
  localparam logic [7:0] KIND_DNER       = 8'd6;
  localparam logic [7:0] KIND_POSTPONED  = 8'd7;
  localparam logic [7:0] NO_FRAME        = 8'd255;

  // Field slots inside one node row
  localparam int F_TOKEN       = 0;
  localparam int F_POLL        = 1;
  localparam int F_RETRY       = 2;
  localparam int F_TOK_REPLY   = 3;
  localparam int F_USAGE       = 4;
  localparam int F_POLL_REPLY  = 5;
  localparam int F_DER         = 6;
  localparam int F_POSTPONED   = 7;
  localparam int STAT_FIELDS   = 8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        frame_valid;
    logic [7:0]  frame_kind;
    logic [7:0]  source_addr;
    logic [7:0]  dest_addr;
    logic [31:0] time_ms;
    logic [7:0]  query_node;
  } req_t;

  typedef struct packed {
    logic [7:0]  node_id;
    logic        node_seen;
    logic [7:0]  highest_polled;
    logic [31:0] tokens_passed;
    logic [31:0] polls_sent;
    logic [31:0] token_repeats;
    logic [31:0] token_reply_max;
    logic [31:0] usage_timeout_max;
    logic [31:0] poll_reply_max;
    logic [31:0] der_reply_max;
    logic [31:0] postponed_max;
    logic [31:0] invalid_total;
  } res_t;

  typedef enum logic [1:0] {
    CMD_FRAME   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_INVALID = 2'd3
  } cmd_op_t;

  typedef struct packed {
    logic bump_token;
    logic bump_poll;
    logic upd_hp;
    logic retry;
    logic usage;
    logic tok_reply;
    logic poll_reply;
    logic der;
    logic postponed;
  } upd_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [31:0] delta;
    upd_t        upd;
  } cmd_t;

endpackage

FILE: sv/tbns_ram.sv
// ----------------------------------------------------------------------------
// tbns_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tbns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/tbns_front.sv
// ----------------------------------------------------------------------------
// tbns_front
// Accepts requests, tracks the previous valid frame and classifies each
// request into a table update command.
// ----------------------------------------------------------------------------
module tbns_front import tbns_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  req_t req,
  output logic push,
  output cmd_t cmd
);

  logic [7:0]  last_kind;
  logic [7:0]  last_source;
  logic [7:0]  last_dest;
  logic [31:0] last_time;
  upd_t        upd;
  logic        is_frame;

  assign is_frame = (req.req_type == REQ_FRAME) && req.frame_valid;

  always_comb begin
    upd = '0;
    unique case (req.frame_kind)
      KIND_TOKEN: begin
        upd.bump_token = 1'b1;
        if (last_kind == KIND_TOKEN) begin
          if (last_dest == req.dest_addr && last_source == req.source_addr) begin
            upd.retry = 1'b1;
            upd.usage = 1'b1;
          end else if (last_dest == req.source_addr) begin
            upd.tok_reply = 1'b1;
          end
        end else if (last_kind == KIND_POLL && last_source == req.source_addr) begin
          upd.usage = 1'b1;
        end
      end
      KIND_POLL: begin
        upd.bump_poll = 1'b1;
        upd.upd_hp    = 1'b1;
        upd.usage     = (last_kind == KIND_POLL) && (last_source == req.source_addr);
      end
      KIND_POLL_REPLY: upd.poll_reply = (last_kind == KIND_POLL);
      KIND_DNER:       upd.der = (last_kind == KIND_DER) && (last_dest == req.source_addr);
      KIND_POSTPONED:  upd.postponed = (last_kind == KIND_DER) &&
                                       (last_dest == req.source_addr);
      default: ;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.src   = req.source_addr;
    cmd.dst   = req.dest_addr;
    cmd.delta = req.time_ms - last_time;
    cmd.upd   = upd;
    push      = 1'b0;
    unique case (req.req_type)
      REQ_FRAME: begin
        cmd.op = req.frame_valid ? CMD_FRAME : CMD_INVALID;
        push   = accept && (!req.frame_valid || (|upd));
      end
      REQ_READ: begin
        cmd.op  = CMD_READ;
        cmd.src = req.query_node;
        push    = accept;
      end
      REQ_CLEAR: begin
        cmd.op = CMD_CLEAR;
        push   = accept;
      end
      default: cmd.op = CMD_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_kind   <= NO_FRAME;
      last_source <= NO_FRAME;
      last_dest   <= NO_FRAME;
      last_time   <= '0;
    end else if (accept && is_frame) begin
      last_kind   <= req.frame_kind;
      last_source <= req.source_addr;
      last_dest   <= req.dest_addr;
      last_time   <= req.time_ms;
    end
  end

endmodule

FILE: sv/tbns_queue.sv
// ----------------------------------------------------------------------------
// tbns_queue
// Short command FIFO between the classifier and the table engine.
// ----------------------------------------------------------------------------
module tbns_queue import tbns_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

FILE: sv/tbns_back.sv
// ----------------------------------------------------------------------------
// tbns_back
// Table engine: read-modify-write of per-node rows, clear, record reads.
// ----------------------------------------------------------------------------
module tbns_back import tbns_pkg::*; #(
  parameter int NUM_NODES  = NUM_NODES_DEF,
  parameter int STAT_WIDTH = STAT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  cmd_t head,
  output logic pop,
  output logic strobe,
  output res_t result
);

  localparam int AW = $clog2(NUM_NODES);
  localparam int SW = STAT_WIDTH;
  localparam int RW = 8 + STAT_FIELDS * SW;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_MOD_SRC = 5'b00010,
    ST_RD_DST  = 5'b00100,
    ST_MOD_DST = 5'b01000,
    ST_READ    = 5'b10000
  } state_t;

  state_t              state;
  cmd_t                cur;
  logic [NUM_NODES-1:0] row_valid;
  logic                rvalid_q;
  logic [SW-1:0]       invalid_cnt;
  logic [AW-1:0]       ram_addr;
  logic                ram_we;
  logic [RW-1:0]       ram_wdata;
  logic [RW-1:0]       ram_rdata;
  logic [RW-1:0]       row;
  logic [SW-1:0]       f [STAT_FIELDS];
  logic [SW-1:0]       nf [STAT_FIELDS];
  logic [7:0]          hp;
  logic [7:0]          nhp;
  logic [SW-1:0]       d;

  tbns_ram #(.WIDTH(RW), .DEPTH(NUM_NODES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign row = rvalid_q ? ram_rdata : '0;
  assign hp  = row[STAT_FIELDS*SW +: 8];
  assign d   = cur.delta[SW-1:0];
  assign pop = (state == ST_IDLE) && !empty;

  always_comb begin
    for (int i = 0; i < STAT_FIELDS; i++) begin
      f[i] = row[i*SW +: SW];
    end
  end

  always_comb begin
    priority if (state == ST_IDLE) begin
      ram_addr = AW'(head.src);
    end else if (state == ST_RD_DST || state == ST_MOD_DST) begin
      ram_addr = AW'(cur.dst);
    end else begin
      ram_addr = AW'(cur.src);
    end
  end

  // Row update
  always_comb begin
    for (int i = 0; i < STAT_FIELDS; i++) begin
      nf[i] = f[i];
    end
    nhp = hp;
    if (state == ST_MOD_DST) begin
      nf[F_RETRY] = f[F_RETRY] + 1'b1;
    end else begin
      if (cur.upd.bump_token) nf[F_TOKEN] = f[F_TOKEN] + 1'b1;
      if (cur.upd.bump_poll)  nf[F_POLL]  = f[F_POLL] + 1'b1;
      if (cur.upd.upd_hp && cur.dst > hp) nhp = cur.dst;
      if (cur.upd.usage && d > f[F_USAGE]) nf[F_USAGE] = d;
      if (cur.upd.tok_reply && d > f[F_TOK_REPLY]) nf[F_TOK_REPLY] = d;
      if (cur.upd.poll_reply && d > f[F_POLL_REPLY]) nf[F_POLL_REPLY] = d;
      if (cur.upd.der && d > f[F_DER]) nf[F_DER] = d;
      if (cur.upd.postponed && d > f[F_POSTPONED]) nf[F_POSTPONED] = d;
    end
    for (int i = 0; i < STAT_FIELDS; i++) begin
      ram_wdata[i*SW +: SW] = nf[i];
    end
    ram_wdata[STAT_FIELDS*SW +: 8] = nhp;
  end

  assign ram_we = (state == ST_MOD_SRC) || (state == ST_MOD_DST);

  always_ff @(posedge clk) begin
    rvalid_q <= row_valid[ram_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      row_valid   <= '0;
      invalid_cnt <= '0;
      strobe      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            unique case (head.op)
              CMD_FRAME:   state <= ST_MOD_SRC;
              CMD_READ:    state <= ST_READ;
              CMD_CLEAR: begin
                row_valid   <= '0;
                invalid_cnt <= '0;
              end
              CMD_INVALID: invalid_cnt <= invalid_cnt + 1'b1;
            endcase
          end
        end
        ST_MOD_SRC: begin
          row_valid[ram_addr] <= 1'b1;
          state <= cur.upd.retry ? ST_RD_DST : ST_IDLE;
        end
        ST_RD_DST: state <= ST_MOD_DST;
        ST_MOD_DST: begin
          row_valid[ram_addr] <= 1'b1;
          state <= ST_IDLE;
        end
        ST_READ: begin
          strobe <= 1'b1;
          state  <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == ST_READ) begin
      result.node_id           <= cur.src;
      result.node_seen         <= (f[F_TOKEN] != '0) || (f[F_POLL] != '0) ||
                                  (f[F_DER] != '0);
      result.highest_polled    <= hp;
      result.tokens_passed     <= 32'(f[F_TOKEN]);
      result.polls_sent        <= 32'(f[F_POLL]);
      result.token_repeats     <= 32'(f[F_RETRY]);
      result.token_reply_max   <= 32'(f[F_TOK_REPLY]);
      result.usage_timeout_max <= 32'(f[F_USAGE]);
      result.poll_reply_max    <= 32'(f[F_POLL_REPLY]);
      result.der_reply_max     <= 32'(f[F_DER]);
      result.postponed_max     <= 32'(f[F_POSTPONED]);
      result.invalid_total     <= 32'(invalid_cnt);
    end
  end

  a_we_in_mod: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_MOD_SRC || state == ST_MOD_DST))
    else $error("table write outside a modify step");

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("record strobe held for two cycles");

  a_strobe_after_read: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == ST_READ))
    else $error("record strobe without a read");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != ST_MOD_DST && state != ST_RD_DST))
    else $error("command taken while a row update is open");

endmodule

FILE: sv/token_bus_node_statistics_top.sv
// ----------------------------------------------------------------------------
// token_bus_node_statistics_top
// Passive statistics monitor for a token-passing RS-485 bus.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Frame, clear and
// invalid transactions give no result; a read transaction gives one record on
// result, marked by strobe for exactly one cycle; both are registered in the
// read state. The receiver cannot stall the block, so a record must be taken
// in the cycle strobe is high. Transactions pass through a two-entry command
// queue: busy rises only when that queue is full. The table engine works one
// command at a time on a single-port node RAM: a frame is a read-modify-write
// of the source row, plus one of the destination row when a repeated token
// charges it; a read passes through the read state; clear and invalid end in
// the idle state. Frames that touch no table cost nothing after acceptance.
// Per-row valid bits make reset and clear instant; there is no clearing pass.
// ----------------------------------------------------------------------------
module token_bus_node_statistics_top import tbns_pkg::*; #(
  parameter int NUM_NODES  = NUM_NODES_DEF,
  parameter int STAT_WIDTH = STAT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic strobe,
  output res_t result
);

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic empty;
  logic full;

  assign busy   = full;
  assign accept = start && !busy;

  // Classifier: keeps the previous valid frame, builds update commands
  tbns_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .push   (push),
    .cmd    (push_cmd)
  );

  // Command queue decouples acceptance from table work
  tbns_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Table engine and record output
  tbns_back #(
    .NUM_NODES  (NUM_NODES),
    .STAT_WIDTH (STAT_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

FILE: tb/token_bus_node_statistics_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_bus_node_statistics_top_test
// Self-checking bench for the bus node statistics monitor. A local model of
// the per-node tables predicts every read record; records are compared field
// by field in arrival order. Directed corner cases come first, then random
// traffic built mostly from plausible token/poll/DER exchanges.
// ----------------------------------------------------------------------------
module token_bus_node_statistics_top_test;
  import tbns_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic strobe;
  res_t result;

  token_bus_node_statistics_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .strobe(strobe), .result(result)
  );

  always #10 clk = ~clk;

  // Model state: per-node tables plus the last valid frame.
  logic [31:0] m_tokens [256];
  logic [31:0] m_polls [256];
  logic [31:0] m_retries [256];
  logic [31:0] m_usage [256];
  logic [7:0]  m_highest [256];
  logic [31:0] m_tok_reply [256];
  logic [31:0] m_poll_reply [256];
  logic [31:0] m_der_reply [256];
  logic [31:0] m_postponed [256];
  logic [7:0]  prev_kind = NO_FRAME;
  logic [7:0]  prev_src = NO_FRAME;
  logic [7:0]  prev_dst = NO_FRAME;
  logic [31:0] prev_time = '0;
  logic [31:0] invalid_count = '0;

  res_t expected_records [$];
  int   error_count = 0;
  int   cycle_count = 0;
  bit   idle_enable = 1'b1;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  function automatic void clear_stats();
    for (int n = 0; n < 256; n++) begin
      m_tokens[n] = '0; m_polls[n] = '0; m_retries[n] = '0; m_usage[n] = '0;
      m_highest[n] = '0; m_tok_reply[n] = '0; m_poll_reply[n] = '0;
      m_der_reply[n] = '0; m_postponed[n] = '0;
    end
    invalid_count = '0;
  endfunction

  function automatic void raise(ref logic [31:0] slot, input logic [31:0] d);
    if (d > slot) slot = d;
  endfunction

  // Apply one accepted transaction to the model; queue a record for reads.
  function automatic void predict(input req_t r);
    logic [31:0] d;
    res_t rec;
    d = r.time_ms - prev_time;
    case (r.req_type)
      REQ_FRAME: begin
        if (!r.frame_valid) begin
          invalid_count++;
        end else begin
          case (r.frame_kind)
            KIND_TOKEN: begin
              m_tokens[r.source_addr]++;
              if (prev_kind == KIND_TOKEN) begin
                if (prev_dst == r.dest_addr && prev_src == r.source_addr) begin
                  m_retries[r.dest_addr]++;
                  raise(m_usage[r.source_addr], d);
                end else if (prev_dst == r.source_addr) begin
                  raise(m_tok_reply[r.source_addr], d);
                end
              end else if (prev_kind == KIND_POLL && prev_src == r.source_addr) begin
                raise(m_usage[r.source_addr], d);
              end
            end
            KIND_POLL: begin
              m_polls[r.source_addr]++;
              if (r.dest_addr > m_highest[r.source_addr])
                m_highest[r.source_addr] = r.dest_addr;
              if (prev_kind == KIND_POLL && prev_src == r.source_addr)
                raise(m_usage[r.source_addr], d);
            end
            KIND_POLL_REPLY: if (prev_kind == KIND_POLL)
              raise(m_poll_reply[r.source_addr], d);
            KIND_DNER: if (prev_kind == KIND_DER && prev_dst == r.source_addr)
              raise(m_der_reply[r.source_addr], d);
            KIND_POSTPONED: if (prev_kind == KIND_DER && prev_dst == r.source_addr)
              raise(m_postponed[r.source_addr], d);
            default: ;
          endcase
          prev_kind = r.frame_kind;
          prev_src = r.source_addr;
          prev_dst = r.dest_addr;
          prev_time = r.time_ms;
        end
      end
      REQ_CLEAR: clear_stats();
      REQ_READ: begin
        rec.node_id = r.query_node;
        rec.node_seen = (m_tokens[r.query_node] != 0) || (m_polls[r.query_node] != 0)
                        || (m_der_reply[r.query_node] != 0);
        rec.highest_polled = m_highest[r.query_node];
        rec.tokens_passed = m_tokens[r.query_node];
        rec.polls_sent = m_polls[r.query_node];
        rec.token_repeats = m_retries[r.query_node];
        rec.token_reply_max = m_tok_reply[r.query_node];
        rec.usage_timeout_max = m_usage[r.query_node];
        rec.poll_reply_max = m_poll_reply[r.query_node];
        rec.der_reply_max = m_der_reply[r.query_node];
        rec.postponed_max = m_postponed[r.query_node];
        rec.invalid_total = invalid_count;
        expected_records.push_back(rec);
      end
      default: ;
    endcase
  endfunction

  // Send one transaction: optional idle burst, then hold start until taken.
  // start is only lowered when an idle burst follows or the stream ends.
  task automatic send(input req_t r);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict(r);
  endtask

  function automatic req_t frame(input logic [7:0] kind, input logic [7:0] src,
                                 input logic [7:0] dst, input logic [31:0] t);
    req_t r;
    r = '0;
    r.req_type = REQ_FRAME; r.frame_valid = 1'b1;
    r.frame_kind = kind; r.source_addr = src; r.dest_addr = dst; r.time_ms = t;
    r.query_node = 8'($urandom);
    return r;
  endfunction

  function automatic req_t read_req(input logic [7:0] node);
    logic [95:0] raw;
    req_t r;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.req_type = REQ_READ; r.query_node = node;
    return r;
  endfunction

  function automatic req_t other_req(input logic [1:0] code);
    logic [95:0] raw;
    req_t r;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.req_type = code;
    return r;
  endfunction

  // Record checker: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst && strobe) begin
      if (expected_records.size() == 0) begin
        report("unexpected record", 32'(result.node_id), '0);
      end else begin
        want = expected_records.pop_front();
        if (result.node_id !== want.node_id)
          report("node_id", 32'(result.node_id), 32'(want.node_id));
        if (result.node_seen !== want.node_seen)
          report("node_seen", 32'(result.node_seen), 32'(want.node_seen));
        if (result.highest_polled !== want.highest_polled)
          report("highest_polled", 32'(result.highest_polled), 32'(want.highest_polled));
        if (result.tokens_passed !== want.tokens_passed)
          report("tokens_passed", result.tokens_passed, want.tokens_passed);
        if (result.polls_sent !== want.polls_sent)
          report("polls_sent", result.polls_sent, want.polls_sent);
        if (result.token_repeats !== want.token_repeats)
          report("token_repeats", result.token_repeats, want.token_repeats);
        if (result.token_reply_max !== want.token_reply_max)
          report("token_reply_max", result.token_reply_max, want.token_reply_max);
        if (result.usage_timeout_max !== want.usage_timeout_max)
          report("usage_timeout_max", result.usage_timeout_max, want.usage_timeout_max);
        if (result.poll_reply_max !== want.poll_reply_max)
          report("poll_reply_max", result.poll_reply_max, want.poll_reply_max);
        if (result.der_reply_max !== want.der_reply_max)
          report("der_reply_max", result.der_reply_max, want.der_reply_max);
        if (result.postponed_max !== want.postponed_max)
          report("postponed_max", result.postponed_max, want.postponed_max);
        if (result.invalid_total !== want.invalid_total)
          report("invalid_total", result.invalid_total, want.invalid_total);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Fresh state: nodes 0 and 255 read back zero.
  task automatic test_reset_state();
    send(read_req(8'd0));
    send(read_req(8'd255));
  endtask

  // Every frame kind and each pairing rule, with field extremes and wrapping
  // timestamps (delay across the 32-bit rollover).
  task automatic test_directed_frames();
    req_t r;
    send(frame(KIND_TOKEN, 8'd3, 8'd7, 32'hFFFF_FFF0));
    send(frame(KIND_TOKEN, 8'd3, 8'd7, 32'h0000_0010));   // repeat across wrap
    send(frame(KIND_TOKEN, 8'd7, 8'd255, 32'h0000_0100)); // reply to token
    send(frame(KIND_POLL, 8'd7, 8'd255, 32'h0000_0200));
    send(frame(KIND_POLL, 8'd7, 8'd0, 32'h0000_0300));    // repeated poll, usage
    send(frame(KIND_TOKEN, 8'd7, 8'd9, 32'h0000_0400));   // token after own poll
    send(frame(KIND_POLL, 8'd255, 8'd128, 32'h0000_0500));
    send(frame(KIND_POLL_REPLY, 8'd128, 8'd255, 32'hFFFF_FFFF));
    send(frame(KIND_DER, 8'd0, 8'd9, 32'h0000_1000));
    send(frame(KIND_DNER, 8'd9, 8'd0, 32'h0000_1234));
    send(frame(KIND_DER, 8'd0, 8'd9, 32'h0000_2000));
    send(frame(KIND_POSTPONED, 8'd9, 8'd0, 32'h0000_2fff));
    send(frame(NO_FRAME, 8'd255, 8'd255, 32'h0));         // unknown kind
    r = other_req(REQ_FRAME);
    r.frame_valid = 1'b0;
    send(r);                                              // invalid frame
    send(other_req(REQ_UNUSED));                          // unused code
    send(read_req(8'd3)); send(read_req(8'd7)); send(read_req(8'd9));
    send(read_req(8'd128)); send(read_req(8'd255));
    send(other_req(REQ_CLEAR));
    send(read_req(8'd7));
  endtask

  // Random traffic: mostly bus-like exchanges between few nodes, some noise.
  task automatic test_random_traffic(input int count);
    req_t r;
    logic [31:0] now;
    logic [7:0] a, b;
    int pick;
    now = $urandom;
    for (int i = 0; i < count; i++) begin
      if (i > count - 200) idle_enable = 1'b0;
      a = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      b = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      now = now + ($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 1000));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        r = read_req($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7)));
      end else if (pick < 11) begin
        r = other_req(REQ_CLEAR);
      end else if (pick < 13) begin
        r = other_req(REQ_UNUSED);
      end else if (pick < 18) begin
        r = frame(8'($urandom), a, b, now);
        r.frame_valid = 1'b0;
      end else if (pick < 25) begin
        r = frame(8'($urandom), a, b, now);
      end else begin
        // follow-on frame shaped by the previous one
        case ($urandom_range(0, 6))
          0: r = frame(KIND_TOKEN, prev_src, prev_dst, now);
          1: r = frame(KIND_TOKEN, prev_dst, b, now);
          2: r = frame(KIND_POLL, $urandom_range(0, 1) ? prev_src : a, b, now);
          3: r = frame(KIND_POLL_REPLY, a, b, now);
          4: r = frame(KIND_DER, a, b, now);
          5: r = frame(KIND_DNER, prev_dst, b, now);
          default: r = frame(KIND_POSTPONED, prev_dst, b, now);
        endcase
      end
      send(r);
    end
  endtask

  initial begin
    int drain;
    clear_stats();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_directed_frames();
    test_random_traffic(1400);
    start <= 1'b0;
    drain = 0;
    while (expected_records.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_records.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
